// ===== hdl/bnms_pkg.sv =====
// Shared types and constants for the box non-maximum suppression block.
// Used by bnms_ctrl, bnms_dp and box_non_maximum_suppression; no dependencies.
`default_nettype none
package bnms_pkg;

  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int THR_W   = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'h8000;
  localparam logic [2:0] DRAIN_LAST = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic [SCORE_W-1:0] confidence;
    logic               last_detection;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] kept_index;
    logic             last_kept;
  } out_req_t;

  typedef struct packed {
    logic             load_we;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] score_addr;
    logic             rank_clear;
    logic             rank_probe;
    logic [IDX_W-1:0] probe_idx;
    logic [IDX_W-1:0] cur_idx;
    logic             order_we;
    logic [IDX_W-1:0] order_addr;
    logic             chk;
    logic             latch_a;
    logic             pair_probe;
    logic             flush;
  } cmd_t;

  typedef struct packed {
    logic sup_hit;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/bnms_ctrl.sv =====
// Sequencer for load, rank sort and suppression walk.
// Depends on bnms_pkg; drives bnms_dp through cmd_t.
`default_nettype none
module bnms_ctrl
  import bnms_pkg::*;
#(
  parameter int MAX_DETS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic last_in,
  output logic      busy,
  output cmd_t      cmd,
  input  sts_t      sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RK_RD  = 4'd1;
  localparam logic [3:0] S_RK_LAT = 4'd2;
  localparam logic [3:0] S_RK_RUN = 4'd3;
  localparam logic [3:0] S_RK_WR  = 4'd4;
  localparam logic [3:0] S_SP_RD  = 4'd5;
  localparam logic [3:0] S_SP_CHK = 4'd6;
  localparam logic [3:0] S_SP_AL  = 4'd7;
  localparam logic [3:0] S_SP_RUN = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;
  localparam logic [3:0] S_FLUSH  = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [2:0]       drain_r, drain_nxt;
  logic [CNT_W-1:0] i_inc;

  assign i_inc = i_r + 1'b1;
  assign busy  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    drain_nxt = drain_r;
    cmd       = '0;
    cmd.wr_idx  = cnt_r[IDX_W-1:0];
    cmd.cur_idx = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (cnt_r < CNT_W'(MAX_DETS)) begin
            cmd.load_we = 1'b1;
            cnt_nxt     = cnt_r + 1'b1;
          end
          if (last_in) begin
            n_nxt     = (cnt_r < CNT_W'(MAX_DETS)) ? cnt_r + 1'b1 : cnt_r;
            i_nxt     = '0;
            state_nxt = S_RK_RD;
          end
        end
      end
      S_RK_RD: begin
        cmd.score_addr = i_r[IDX_W-1:0];
        state_nxt      = S_RK_LAT;
      end
      S_RK_LAT: begin
        cmd.rank_clear = 1'b1;
        j_nxt          = '0;
        state_nxt      = S_RK_RUN;
      end
      S_RK_RUN: begin
        if (j_r < n_r) begin
          cmd.score_addr = j_r[IDX_W-1:0];
          cmd.rank_probe = 1'b1;
          cmd.probe_idx  = j_r[IDX_W-1:0];
          j_nxt          = j_r + 1'b1;
        end else begin
          state_nxt = S_RK_WR;
        end
      end
      S_RK_WR: begin
        cmd.order_we = 1'b1;
        if (i_inc == n_r) begin
          i_nxt     = '0;
          state_nxt = S_SP_RD;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_RK_RD;
        end
      end
      S_SP_RD: begin
        cmd.order_addr = i_r[IDX_W-1:0];
        state_nxt      = S_SP_CHK;
      end
      S_SP_CHK: begin
        cmd.chk = 1'b1;
        if (sts.sup_hit) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == n_r) ? S_FLUSH : S_SP_RD;
        end else begin
          j_nxt     = i_inc;
          state_nxt = S_SP_AL;
        end
      end
      S_SP_AL: begin
        cmd.latch_a = 1'b1;
        state_nxt   = S_SP_RUN;
      end
      S_SP_RUN: begin
        if (j_r < n_r) begin
          cmd.order_addr = j_r[IDX_W-1:0];
          cmd.pair_probe = 1'b1;
          j_nxt          = j_r + 1'b1;
        end else begin
          drain_nxt = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DRAIN_LAST) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == n_r) ? S_FLUSH : S_SP_RD;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    drain_r <= drain_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/bnms_dp.sv =====
// Datapath: box, score and order stores, rank counter, IoU pipeline, flags.
// Depends on bnms_pkg; steered by bnms_ctrl through cmd_t.
`default_nettype none
module bnms_dp
  import bnms_pkg::*;
#(
  parameter int MAX_DETS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  in_req_t               in_req,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata,
  output logic                  out_strobe,
  output out_req_t              out_req
);

  logic [4*COORD_W-1:0] box_mem   [MAX_DETS];
  logic [SCORE_W-1:0]   score_mem [MAX_DETS];
  logic [IDX_W-1:0]     order_mem [MAX_DETS];

  logic [4*COORD_W-1:0] box_q;
  logic [SCORE_W-1:0]   score_q;
  logic [IDX_W-1:0]     order_q;
  logic [THR_W-1:0]     thr_r;

  // rank sort
  logic [SCORE_W-1:0] si_r;
  logic [IDX_W-1:0]   rank_r;
  logic               rk_v_r;
  logic [IDX_W-1:0]   rk_j_r;
  logic               rk_ahead;

  // suppression
  logic [MAX_DETS-1:0] flags_r;
  logic                pend_v_r;
  logic [IDX_W-1:0]    pend_r;
  logic                keep;

  logic [COORD_W-1:0] al_r, at_r, ar_r, ab_r;
  logic signed [2*COORD_W+1:0] area_a_r;
  logic signed [COORD_W:0] aw, ah;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [IDX_W-1:0] kj2_r, kj3_r, kj4_r, kj5_r, kj6_r;
  logic [COORD_W-1:0] bl, bt, br, bb, ix1, iy1, ix2, iy2;
  logic [COORD_W:0]   wd, hd;
  logic signed [COORD_W:0] bw, bh;
  logic [COORD_W-1:0] w3_r, h3_r;
  logic signed [COORD_W:0] bw3_r, bh3_r;
  logic [2*COORD_W-1:0] inter4_r, inter5_r, inter6_r;
  logic signed [2*COORD_W+1:0] area_b4_r;
  logic signed [2*COORD_W+3:0] uni5_r;
  logic signed [THR_W+2*COORD_W+4:0] rhs6_r;
  logic signed [3*COORD_W:0] lhs6;
  logic over;

  // stores
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      box_mem[cmd.wr_idx]   <= {in_req.box_bottom, in_req.box_right,
                                in_req.box_top, in_req.box_left};
      score_mem[cmd.wr_idx] <= in_req.confidence;
    end
    score_q <= score_mem[cmd.score_addr];
    if (cmd.order_we) begin
      order_mem[rank_r] <= cmd.cur_idx;
    end
    order_q <= order_mem[cmd.order_addr];
    box_q   <= box_mem[order_q];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // rank: count entries that sort ahead of the current one
  assign rk_ahead = (score_q > si_r) || ((score_q == si_r) && (rk_j_r < cmd.cur_idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_v_r <= 1'b0;
    end else begin
      rk_v_r <= cmd.rank_probe;
    end
    rk_j_r <= cmd.probe_idx;
    if (cmd.rank_clear) begin
      si_r   <= score_q;
      rank_r <= '0;
    end else if (rk_v_r && rk_ahead) begin
      rank_r <= rank_r + 1'b1;
    end
  end

  // keep decision and result emission
  assign sts.sup_hit = flags_r[order_q];
  assign keep        = cmd.chk && !flags_r[order_q];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (keep && pend_v_r) || cmd.flush;
      if (keep) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
    end
    if (keep) begin
      pend_r <= order_q;
    end
    out_req.kept_index <= pend_r;
    out_req.last_kept  <= cmd.flush;
  end

  // reference box and its area
  assign aw = $signed({1'b0, ar_r}) - $signed({1'b0, al_r});
  assign ah = $signed({1'b0, ab_r}) - $signed({1'b0, at_r});

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      al_r <= box_q[COORD_W-1:0];
      at_r <= box_q[2*COORD_W-1:COORD_W];
      ar_r <= box_q[3*COORD_W-1:2*COORD_W];
      ab_r <= box_q[4*COORD_W-1:3*COORD_W];
    end
    area_a_r <= aw * ah;
  end

  // pair pipeline
  assign bl  = box_q[COORD_W-1:0];
  assign bt  = box_q[2*COORD_W-1:COORD_W];
  assign br  = box_q[3*COORD_W-1:2*COORD_W];
  assign bb  = box_q[4*COORD_W-1:3*COORD_W];
  assign ix1 = (al_r > bl) ? al_r : bl;
  assign iy1 = (at_r > bt) ? at_r : bt;
  assign ix2 = (ar_r < br) ? ar_r : br;
  assign iy2 = (ab_r < bb) ? ab_r : bb;
  assign wd  = {1'b0, ix2} - {1'b0, ix1};
  assign hd  = {1'b0, iy2} - {1'b0, iy1};
  assign bw  = $signed({1'b0, br}) - $signed({1'b0, bl});
  assign bh  = $signed({1'b0, bb}) - $signed({1'b0, bt});
  assign lhs6 = $signed({1'b0, inter6_r, {COORD_W{1'b0}}});
  assign over = lhs6 > rhs6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= cmd.pair_probe;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    kj2_r <= order_q;
    kj3_r <= kj2_r;
    kj4_r <= kj3_r;
    kj5_r <= kj4_r;
    kj6_r <= kj5_r;
    w3_r  <= wd[COORD_W] ? '0 : wd[COORD_W-1:0];
    h3_r  <= hd[COORD_W] ? '0 : hd[COORD_W-1:0];
    bw3_r <= bw;
    bh3_r <= bh;
    inter4_r  <= w3_r * h3_r;
    area_b4_r <= bw3_r * bh3_r;
    uni5_r    <= (2*COORD_W+4)'(area_a_r) + (2*COORD_W+4)'(area_b4_r)
               - $signed({4'b0, inter4_r});
    inter5_r  <= inter4_r;
    rhs6_r    <= $signed({1'b0, thr_r}) * uni5_r;
    inter6_r  <= inter5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (cmd.flush) begin
      flags_r <= '0;
    end else if (v6_r && over) begin
      flags_r[kj6_r] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/box_non_maximum_suppression.sv =====
// Greedy IoU non-maximum suppression over up to MAX_DETS boxes per set.
// Load: one box per cycle, busy stays low. On the last box a rank sort orders the boxes,
// then the walk checks each in sorted order and, for each kept box, runs the IoU pipeline
// over the boxes after it and drains it, then flushes. Each kept index is strobed in the
// cycle after the next keep, the final one in the cycle after the flush, flagged.
// Reset (rst_n, synchronous): empty set, no flags, threshold 0.5; receiver cannot stall.
`default_nettype none
module box_non_maximum_suppression
  import bnms_pkg::*;
#(
  parameter int MAX_DETS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  in_req_t               in_req,
  output logic                  out_strobe,
  output out_req_t              out_req,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // controller: load count, rank sort sweep, greedy walk
  bnms_ctrl #(.MAX_DETS(MAX_DETS)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .last_in (in_req.last_detection),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  // datapath: stores, rank counter, IoU pipeline, suppression flags
  bnms_dp #(.MAX_DETS(MAX_DETS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_req    (out_req)
  );

endmodule
`default_nettype wire

// ===== dv/tb_box_non_maximum_suppression.sv =====
// Testbench for box_non_maximum_suppression: loads sets of boxes, predicts the
// kept indices with a greedy IoU suppression model and checks each strobed result.
// Depends on bnms_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_box_non_maximum_suppression;
  import bnms_pkg::*;

  localparam int MAX_DETS = 64;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_req_t in_req;
  logic out_strobe;
  out_req_t out_req;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  box_non_maximum_suppression #(.MAX_DETS(MAX_DETS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_req(out_req), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Predictor state: the current set of loaded boxes and the threshold.
  in_req_t set_boxes[MAX_DETS];
  int unsigned set_count;
  logic [THR_W-1:0] iou_threshold;
  out_req_t kept_queue[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  // Cross-multiplied IoU test, signed areas, intersection clamped at zero.
  function automatic bit too_much_overlap(in_req_t a, in_req_t b);
    longint ix1, iy1, ix2, iy2, w, h, inter, uni;
    ix1 = (a.box_left > b.box_left) ? a.box_left : b.box_left;
    iy1 = (a.box_top > b.box_top) ? a.box_top : b.box_top;
    ix2 = (a.box_right < b.box_right) ? a.box_right : b.box_right;
    iy2 = (a.box_bottom < b.box_bottom) ? a.box_bottom : b.box_bottom;
    w = ix2 - ix1;
    h = iy2 - iy1;
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    inter = w * h;
    uni = (longint'(a.box_right) - longint'(a.box_left)) *
          (longint'(a.box_bottom) - longint'(a.box_top)) +
          (longint'(b.box_right) - longint'(b.box_left)) *
          (longint'(b.box_bottom) - longint'(b.box_top)) - inter;
    return inter * 65536 > longint'(iou_threshold) * uni;
  endfunction

  // Sort by descending score (stable), walk greedily, queue the kept indices.
  task automatic predict_kept_set();
    int order[$];
    bit suppressed[MAX_DETS];
    int j;
    int first;
    out_req_t r;
    first = kept_queue.size();
    for (int i = 0; i < set_count; i++) begin
      j = 0;
      while (j < order.size() && set_boxes[order[j]].confidence >= set_boxes[i].confidence)
        j++;
      order.insert(j, i);
      suppressed[i] = 1'b0;
    end
    for (int i = 0; i < set_count; i++) begin
      if (suppressed[order[i]]) continue;
      r.kept_index = IDX_W'(order[i]);
      r.last_kept = 1'b0;
      kept_queue.insert(kept_queue.size(), r);
      for (int k = i + 1; k < set_count; k++)
        if (!suppressed[order[k]] && too_much_overlap(set_boxes[order[i]], set_boxes[order[k]]))
          suppressed[order[k]] = 1'b1;
    end
    if (kept_queue.size() > first) kept_queue[$].last_kept = 1'b1;
    set_count = 0;
  endtask

  // Send one request: wait for not busy, hold start for the accepting edge.
  task automatic send_box(in_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    start = 1'b1;
    in_req = req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (set_count < MAX_DETS) begin
      set_boxes[set_count] = req;
      set_count++;
    end
    if (req.last_detection) predict_kept_set();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until all expected results came, then give the block room to settle.
  task automatic drain_results();
    while (kept_queue.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write the threshold only while idle.
  task automatic write_threshold(logic [THR_W-1:0] thr);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = thr;
    iou_threshold = thr;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic in_req_t make_box(int unsigned l, int unsigned t, int unsigned r,
                                       int unsigned b, int unsigned s, bit last);
    in_req_t q;
    q.box_left = COORD_W'(l);
    q.box_top = COORD_W'(t);
    q.box_right = COORD_W'(r);
    q.box_bottom = COORD_W'(b);
    q.confidence = SCORE_W'(s);
    q.last_detection = last;
    return q;
  endfunction

  // Random box: mostly clustered near a center so that overlaps happen,
  // sometimes full range including inverted corners.
  function automatic in_req_t random_box(bit last);
    int unsigned cx, cy, l, t;
    if ($urandom_range(0, 4) == 0)
      return make_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), last);
    cx = $urandom_range(0, 3) * 16000;
    cy = $urandom_range(0, 3) * 16000;
    l = cx + $urandom_range(0, 800);
    t = cy + $urandom_range(0, 800);
    return make_box(l, t, l + $urandom_range(200, 1600), t + $urandom_range(200, 1600),
                    ($urandom_range(0, 3) == 0) ? 16'h4000 : $urandom_range(0, 65535),
                    last);
  endfunction

  task automatic send_random_set(int unsigned n);
    for (int i = 0; i < n; i++) send_box(random_box(i == n - 1));
  endtask

  // Corners and scores at their extremes, ties, inverted and zero-area boxes.
  task automatic test_directed_extremes();
    send_box(make_box(0, 0, 65535, 65535, 65535, 1'b0));
    send_box(make_box(0, 0, 65535, 65535, 65535, 1'b0));
    send_box(make_box(65535, 65535, 0, 0, 0, 1'b0));
    send_box(make_box(100, 100, 100, 100, 0, 1'b0));
    send_box(make_box(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h8000, 1'b0));
    send_box(make_box(16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b0));
    send_box(make_box(10, 10, 200, 200, 1, 1'b1));
    drain_results();
    // Single box set, then a set with disjoint boxes.
    send_box(make_box(1, 2, 3, 4, 5, 1'b1));
    send_box(make_box(0, 0, 100, 100, 300, 1'b0));
    send_box(make_box(500, 500, 600, 600, 200, 1'b0));
    send_box(make_box(1000, 0, 1100, 100, 300, 1'b1));
  endtask

  // Fill past the store: extra boxes are dropped, a dropped last still runs.
  task automatic test_store_full();
    for (int i = 0; i < MAX_DETS + 3; i++)
      send_box(random_box(i == MAX_DETS + 2));
  endtask

  task automatic test_thresholds();
    write_threshold(16'h0000);
    send_random_set(8);
    write_threshold(16'hFFFF);
    send_random_set(8);
    write_threshold(16'h1000);
    send_random_set(6);
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    write_threshold(THR_RESET);
    while (sent < 60) begin
      if ($urandom_range(0, 9) == 0)
        write_threshold(THR_W'($urandom_range(0, 65535)));
      n = $urandom_range(1, 12);
      send_random_set(n);
      sent += n;
    end
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    out_req_t exp_kept;
    if (rst_n && out_strobe) begin
      if (kept_queue.size() == 0) begin
        $error("kept result with none expected: kept_index %0d", out_req.kept_index);
        fail_count++;
      end else begin
        exp_kept = kept_queue.pop_front();
        if (out_req.kept_index !== exp_kept.kept_index) begin
          $error("kept_index expected %0d actual %0d", exp_kept.kept_index, out_req.kept_index);
          fail_count++;
        end
        if (out_req.last_kept !== exp_kept.last_kept) begin
          $error("last_kept expected %0d actual %0d", exp_kept.last_kept, out_req.last_kept);
          fail_count++;
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("box_non_maximum_suppression: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    set_count = 0;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 0;
    iou_threshold = THR_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed_extremes();
    test_store_full();
    test_thresholds();
    test_random_sets();
    drain_results();
    if (kept_queue.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("box_non_maximum_suppression: match");
    end else begin
      $display("box_non_maximum_suppression: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
